FILE: src/rbsi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_pkg
// Shared constants, word types and stage records for the ray / box slab
// intersection pipeline.
// ---------------------------------------------------------------------------
package rbsi_pkg;

	// fixed point format
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	// magnitude of a 33 bit difference
	localparam int MAG_W     = DATA_W + 1;
	// dividend: magnitude scaled by the fraction bits
	localparam int NUM_W     = MAG_W + FRAC_BITS;
	// dividend bits above the 32 quotient bits
	localparam int HI_W      = NUM_W - DATA_W;

	// divider: quotient bits resolved per pipeline stage
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = DATA_W / STEPS_PER_STAGE;

	localparam int NUM_AXES  = 3;
	localparam int NUM_SLOTS = 2 * NUM_AXES;
	localparam int FACE_W    = 3;

	// hit point arithmetic
	localparam int PROD_W = 2 * DATA_W;
	localparam int SHR_W  = PROD_W - FRAC_BITS;
	localparam int SUM_W  = SHR_W + 1;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic [NUM_AXES-1:0][DATA_W-1:0] vec3_t;
	typedef logic [NUM_SLOTS-1:0][DATA_W-1:0] slots_t;

	// input word: one ray and one box
	typedef struct packed {
		fix_t box_min_x;
		fix_t box_min_y;
		fix_t box_min_z;
		fix_t box_max_x;
		fix_t box_max_y;
		fix_t box_max_z;
		fix_t origin_x;
		fix_t origin_y;
		fix_t origin_z;
		fix_t dir_x;
		fix_t dir_y;
		fix_t dir_z;
	} req_t;

	// result word
	typedef struct packed {
		logic              hit;
		fix_t              distance;
		fix_t              point_x;
		fix_t              point_y;
		fix_t              point_z;
		logic [FACE_W-1:0] face;
	} rsp_t;

	// ray data carried alongside the divider
	typedef struct packed {
		vec3_t org;
		vec3_t dir;
	} side_t;

	// divider output: six saturated slab distances plus the ray
	typedef struct packed {
		slots_t t;
		side_t  side;
	} slab_t;

	// selection output
	typedef struct packed {
		logic              hit;
		fix_t              distance;
		logic [FACE_W-1:0] face;
		side_t             side;
	} hitinfo_t;

endpackage

`default_nettype wire

FILE: src/rbsi_slab_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_slab_div
// Six parallel pipelined dividers forming the slab distances
// ((bound - origin) << FRAC_BITS) / dir, truncated and saturated.
// ---------------------------------------------------------------------------
module rbsi_slab_div import rbsi_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  req_valid,
	input  req_t  req,
	output logic  slab_valid,
	output slab_t slab
);

	typedef struct packed {
		logic [MAG_W-1:0]  mag;
		logic [DATA_W-1:0] dmag;
		logic              neg;
	} prep_t;

	typedef struct packed {
		logic [DATA_W-1:0] rem;
		logic [DATA_W-1:0] nq;   // dividend bits out, quotient bits in
		logic [DATA_W-1:0] dmag;
		logic              neg;
		logic              ovf;
	} lane_t;

	// restoring division steps
	function automatic lane_t div_steps(input lane_t l);
		lane_t           o;
		logic [DATA_W:0] r2;
		logic            qb;
		o = l;
		for (int k = 0; k < STEPS_PER_STAGE; k++) begin
			r2 = {o.rem, o.nq[DATA_W-1]};
			qb = (r2 >= {1'b0, o.dmag});
			if (qb) begin
				o.rem = DATA_W'(r2 - {1'b0, o.dmag});
			end else begin
				o.rem = r2[DATA_W-1:0];
			end
			o.nq = {o.nq[DATA_W-2:0], qb};
		end
		return o;
	endfunction

	// apply sign and saturate to 32 bits
	function automatic logic [DATA_W-1:0] sat_quot(input lane_t l);
		logic [DATA_W-1:0] q;
		q = l.nq;
		if (!l.neg) begin
			return (l.ovf || q[DATA_W-1]) ? S32_MAX : q;
		end
		return (l.ovf || (q[DATA_W-1] && (|q[DATA_W-2:0]))) ? S32_MIN : (~q + 1'b1);
	endfunction

	fix_t bnd [NUM_SLOTS];
	fix_t org3 [NUM_AXES];
	fix_t dir3 [NUM_AXES];

	prep_t prep_c [NUM_SLOTS];
	prep_t prep_s1 [NUM_SLOTS];
	side_t side_s1, side_s2;
	lane_t init_c [NUM_SLOTS];
	lane_t init_s2 [NUM_SLOTS];
	lane_t iter_s [DIV_STAGES][NUM_SLOTS];
	side_t iter_side_s [DIV_STAGES];
	logic  val_s1, val_s2;
	logic  iter_val_s [DIV_STAGES];
	side_t side_c;

	// unpack the word by slot
	always_comb begin
		bnd[0]  = req.box_min_x;
		bnd[1]  = req.box_max_x;
		bnd[2]  = req.box_min_y;
		bnd[3]  = req.box_max_y;
		bnd[4]  = req.box_min_z;
		bnd[5]  = req.box_max_z;
		org3[0] = req.origin_x;
		org3[1] = req.origin_y;
		org3[2] = req.origin_z;
		dir3[0] = req.dir_x;
		dir3[1] = req.dir_y;
		dir3[2] = req.dir_z;
		for (int a = 0; a < NUM_AXES; a++) begin
			side_c.org[a] = org3[a];
			side_c.dir[a] = dir3[a];
		end
	end

	// magnitudes and quotient sign
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_prep
		logic signed [MAG_W-1:0] diff;
		fix_t                    dirc;
		assign diff = {bnd[i][DATA_W-1], bnd[i]} - {org3[i/2][DATA_W-1], org3[i/2]};
		assign dirc = (dir3[i/2] == '0) ? fix_t'(1) : dir3[i/2];
		always_comb begin
			prep_c[i].mag  = diff[MAG_W-1] ? (~diff + 1'b1) : diff;
			prep_c[i].dmag = dirc[DATA_W-1] ? (~dirc + 1'b1) : dirc;
			prep_c[i].neg  = diff[MAG_W-1] ^ dirc[DATA_W-1];
		end
	end

	// overflow check and divider start
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			init_c[i].rem  = {{(DATA_W-HI_W){1'b0}}, prep_s1[i].mag[MAG_W-1 -: HI_W]};
			init_c[i].nq   = {prep_s1[i].mag[DATA_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
			init_c[i].dmag = prep_s1[i].dmag;
			init_c[i].neg  = prep_s1[i].neg;
			init_c[i].ovf  = ({{(DATA_W-HI_W){1'b0}}, prep_s1[i].mag[MAG_W-1 -: HI_W]}
				>= prep_s1[i].dmag);
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1     <= 1'b0;
			val_s2     <= 1'b0;
			slab_valid <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) iter_val_s[k] <= 1'b0;
		end else if (en) begin
			val_s1        <= req_valid;
			val_s2        <= val_s1;
			iter_val_s[0] <= val_s2;
			for (int k = 1; k < DIV_STAGES; k++) iter_val_s[k] <= iter_val_s[k-1];
			slab_valid    <= iter_val_s[DIV_STAGES-1];
		end
	end

	// data path
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1        <= side_c;
			side_s2        <= side_s1;
			iter_side_s[0] <= side_s2;
			for (int k = 1; k < DIV_STAGES; k++) iter_side_s[k] <= iter_side_s[k-1];
			slab.side      <= iter_side_s[DIV_STAGES-1];
			for (int i = 0; i < NUM_SLOTS; i++) begin
				prep_s1[i]   <= prep_c[i];
				init_s2[i]   <= init_c[i];
				iter_s[0][i] <= div_steps(init_s2[i]);
				for (int k = 1; k < DIV_STAGES; k++) iter_s[k][i] <= div_steps(iter_s[k-1][i]);
				slab.t[i]    <= sat_quot(iter_s[DIV_STAGES-1][i]);
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/rbsi_select.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_select
// Near/far ordering per axis, tmin/tmax reduction, hit test, distance and
// face choice. Three register stages.
// ---------------------------------------------------------------------------
module rbsi_select import rbsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     slab_valid,
	input  slab_t    slab,
	output logic     hinfo_valid,
	output hitinfo_t hinfo
);

	fix_t   lo_c [NUM_AXES];
	fix_t   hi_c [NUM_AXES];
	fix_t   lo_s1 [NUM_AXES];
	fix_t   hi_s1 [NUM_AXES];
	slots_t t_s1, t_s2;
	side_t  side_s1, side_s2;
	fix_t   tmin_c, tmax_c, tmin_s2, tmax_s2;
	logic   val_s1, val_s2;
	logic   hit_c;
	fix_t   dist_c;
	logic [FACE_W-1:0] face_c;

	// order each slab pair
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			if (signed'(slab.t[2*a]) < signed'(slab.t[2*a+1])) begin
				lo_c[a] = slab.t[2*a];
				hi_c[a] = slab.t[2*a+1];
			end else begin
				lo_c[a] = slab.t[2*a+1];
				hi_c[a] = slab.t[2*a];
			end
		end
	end

	// largest near, smallest far
	always_comb begin
		tmin_c = lo_s1[0];
		tmax_c = hi_s1[0];
		for (int a = 1; a < NUM_AXES; a++) begin
			if (lo_s1[a] > tmin_c) tmin_c = lo_s1[a];
			if (hi_s1[a] < tmax_c) tmax_c = hi_s1[a];
		end
	end

	// hit test, distance, last matching slot
	always_comb begin
		hit_c  = !(tmax_s2 < 0) && !(tmin_s2 > tmax_s2);
		dist_c = (tmin_s2 < 0) ? tmax_s2 : tmin_s2;
		face_c = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (signed'(t_s2[i]) == dist_c) face_c = FACE_W'(i);
		end
		if (!hit_c) begin
			dist_c = '0;
			face_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1      <= 1'b0;
			val_s2      <= 1'b0;
			hinfo_valid <= 1'b0;
		end else if (en) begin
			val_s1      <= slab_valid;
			val_s2      <= val_s1;
			hinfo_valid <= val_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				lo_s1[a] <= lo_c[a];
				hi_s1[a] <= hi_c[a];
			end
			t_s1           <= slab.t;
			side_s1        <= slab.side;
			tmin_s2        <= tmin_c;
			tmax_s2        <= tmax_c;
			t_s2           <= t_s1;
			side_s2        <= side_s1;
			hinfo.hit      <= hit_c;
			hinfo.distance <= dist_c;
			hinfo.face     <= face_c;
			hinfo.side     <= side_s2;
		end
	end

endmodule

`default_nettype wire

FILE: src/rbsi_point.sv
`default_nettype none
// ---------------------------------------------------------------------------
// rbsi_point
// Hit point: origin + floor(distance * dir / 2^FRAC_BITS), saturated.
// Multiply stage, then shift/add/saturate into the output register.
// ---------------------------------------------------------------------------
module rbsi_point import rbsi_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     hinfo_valid,
	input  hitinfo_t hinfo,
	output logic     rsp_valid,
	output rsp_t     rsp
);

	function automatic fix_t sat_sum(input logic signed [SUM_W-1:0] s);
		if (s > SUM_W'(S32_MAX)) return S32_MAX;
		if (s < SUM_W'(S32_MIN)) return S32_MIN;
		return s[DATA_W-1:0];
	endfunction

	logic signed [PROD_W-1:0] prod_s1 [NUM_AXES];
	vec3_t                    org_s1;
	logic                     hit_s1;
	fix_t                     dist_s1;
	logic [FACE_W-1:0]        face_s1;
	logic                     val_s1;
	fix_t                     pt_c [NUM_AXES];

	// floor shift, add origin, saturate; zero on miss
	always_comb begin
		for (int a = 0; a < NUM_AXES; a++) begin
			pt_c[a] = sat_sum({{(SUM_W-DATA_W){org_s1[a][DATA_W-1]}}, org_s1[a]}
				+ {prod_s1[a][PROD_W-1], prod_s1[a][PROD_W-1:FRAC_BITS]});
			if (!hit_s1) pt_c[a] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1    <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			val_s1    <= hinfo_valid;
			rsp_valid <= val_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				prod_s1[a] <= hinfo.distance * signed'(hinfo.side.dir[a]);
			end
			org_s1       <= hinfo.side.org;
			hit_s1       <= hinfo.hit;
			dist_s1      <= hinfo.distance;
			face_s1      <= hinfo.face;
			rsp.hit      <= hit_s1;
			rsp.distance <= dist_s1;
			rsp.point_x  <= pt_c[0];
			rsp.point_y  <= pt_c[1];
			rsp.point_z  <= pt_c[2];
			rsp.face     <= face_s1;
		end
	end

endmodule

`default_nettype wire

FILE: src/ray_box_slab_intersect_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ray_box_slab_intersect_top
// Ray against axis-aligned box by the slab method, signed fixed point.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             word
//  req      in   req_valid/req_stall   req_t: box corners, origin, direction
//  rsp      out  rsp_valid/rsp_stall   rsp_t: hit, distance, point, face
//
//  One word accepted per cycle while not stalled; the divider resolves two
//  quotient bits per stage over 16 stages, which sets the depth.
//  Reset clears only the valid bits; no clearing pass.
//  A stalled result freezes the whole pipeline, and req_stall follows.
// ---------------------------------------------------------------------------
module ray_box_slab_intersect_top import rbsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	logic     en;
	logic     slab_valid;
	slab_t    slab;
	logic     hinfo_valid;
	hitinfo_t hinfo;

	// pipeline advances unless a result is held
	assign en        = !(rsp_valid && rsp_stall);
	assign req_stall = !en;

	rbsi_slab_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.req_valid  (req_valid),
		.req        (req),
		.slab_valid (slab_valid),
		.slab       (slab)
	);

	rbsi_select u_sel (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.slab_valid  (slab_valid),
		.slab        (slab),
		.hinfo_valid (hinfo_valid),
		.hinfo       (hinfo)
	);

	rbsi_point u_pt (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.hinfo_valid (hinfo_valid),
		.hinfo       (hinfo),
		.rsp_valid   (rsp_valid),
		.rsp         (rsp)
	);

endmodule

`default_nettype wire

FILE: verif/tb_ray_box_slab_intersect_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ray_box_slab_intersect_top
// Self-checking bench for the ray / box slab intersection pipeline. Directed
// rows (misses, origin inside, zero direction, saturation, inverted boxes)
// are followed by random rays and boxes. Every result word is compared
// field by field against a local fixed point model, with random gaps on the
// request channel and random stalls on the result channel.
// ---------------------------------------------------------------------------
module tb_ray_box_slab_intersect_top;
	import rbsi_pkg::*;

	localparam int LATENCY   = 24;
	localparam int N_RANDOM  = 650;
	localparam int WDOG_MAX  = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	rsp_t hit_q[$];
	int   errors = 0;
	int   n_sent = 0;
	int   n_recv = 0;
	int   n_hits = 0;
	int   idle_cycles = 0;

	// directed row: word plus an optional typed expectation
	typedef struct {
		req_t w;
		bit   typed;
		rsp_t exp;
	} row_t;
	row_t rows[$];

	always #2 clk = ~clk;

	ray_box_slab_intersect_top dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// slab distance, quotient truncated toward zero
	function automatic longint slab_dist(fix_t bound, fix_t org, fix_t dir);
		longint num, d;
		num = (longint'(bound) - longint'(org)) * (64'sd1 <<< FRAC_BITS);
		d = (dir == 0) ? 64'sd1 : longint'(dir);
		return clamp32(num / d);
	endfunction

	function automatic rsp_t box_hit(req_t w);
		longint t[6], lo, hi, tmin, tmax, t_hit;
		fix_t   o[3], dr[3], bl[3], bh[3];
		rsp_t   r;
		o  = '{w.origin_x, w.origin_y, w.origin_z};
		dr = '{w.dir_x, w.dir_y, w.dir_z};
		bl = '{w.box_min_x, w.box_min_y, w.box_min_z};
		bh = '{w.box_max_x, w.box_max_y, w.box_max_z};
		r = '0;
		tmin = 0;
		tmax = 0;
		for (int a = 0; a < 3; a++) begin
			t[2*a]   = slab_dist(bl[a], o[a], dr[a]);
			t[2*a+1] = slab_dist(bh[a], o[a], dr[a]);
			lo = (t[2*a] < t[2*a+1]) ? t[2*a] : t[2*a+1];
			hi = (t[2*a] < t[2*a+1]) ? t[2*a+1] : t[2*a];
			if (a == 0 || lo > tmin) tmin = lo;
			if (a == 0 || hi < tmax) tmax = hi;
		end
		if (tmax < 0 || tmin > tmax) return r;
		t_hit = (tmin < 0) ? tmax : tmin;
		r.hit = 1'b1;
		r.distance = fix_t'(t_hit);
		for (int i = 0; i < 6; i++)
			if (t[i] == t_hit) r.face = i[FACE_W-1:0];
		// arithmetic shift is floor division by 2^FRAC_BITS
		r.point_x = fix_t'(clamp32(longint'(o[0]) + ((t_hit * longint'(dr[0])) >>> FRAC_BITS)));
		r.point_y = fix_t'(clamp32(longint'(o[1]) + ((t_hit * longint'(dr[1])) >>> FRAC_BITS)));
		r.point_z = fix_t'(clamp32(longint'(o[2]) + ((t_hit * longint'(dr[2])) >>> FRAC_BITS)));
		return r;
	endfunction

	function automatic fix_t q(int v);
		return fix_t'(v <<< FRAC_BITS);
	endfunction

	function automatic req_t mk(fix_t x0, fix_t y0, fix_t z0, fix_t x1, fix_t y1, fix_t z1,
			fix_t ox, fix_t oy, fix_t oz, fix_t dx, fix_t dy, fix_t dz);
		req_t w;
		w = '{x0, y0, z0, x1, y1, z1, ox, oy, oz, dx, dy, dz};
		return w;
	endfunction

	function automatic fix_t rnd_field();
		case ($urandom_range(0, 9))
			0: return S32_MAX;
			1: return S32_MIN;
			2: return '0;
			3, 4: return fix_t'($urandom);
			default: return fix_t'($signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000);
		endcase
	endfunction

	// well-formed: small box, ray often aimed at its center, or random noise
	function automatic req_t rnd_word();
		req_t w;
		fix_t c[3], h[3];
		if ($urandom_range(0, 3) == 0) begin
			w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			for (int i = 0; i < 12; i++)
				if ($urandom_range(0, 7) == 0) w[i*32 +: 32] = rnd_field();
			return w;
		end
		for (int a = 0; a < 3; a++) begin
			c[a] = fix_t'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
			h[a] = fix_t'($urandom_range(1, 32'h00200000));
		end
		w.box_min_x = c[0] - h[0]; w.box_max_x = c[0] + h[0];
		w.box_min_y = c[1] - h[1]; w.box_max_y = c[1] + h[1];
		w.box_min_z = c[2] - h[2]; w.box_max_z = c[2] + h[2];
		w.origin_x = rnd_field(); w.origin_y = rnd_field(); w.origin_z = rnd_field();
		if ($urandom_range(0, 2) != 0) begin
			// aim toward the box center
			w.origin_x = fix_t'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
			w.origin_y = fix_t'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
			w.origin_z = fix_t'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
			w.dir_x = (c[0] - w.origin_x) >>> $urandom_range(4, 10);
			w.dir_y = (c[1] - w.origin_y) >>> $urandom_range(4, 10);
			w.dir_z = (c[2] - w.origin_z) >>> $urandom_range(4, 10);
		end else begin
			w.dir_x = rnd_field(); w.dir_y = rnd_field(); w.dir_z = rnd_field();
		end
		return w;
	endfunction

	// no gap half the time, otherwise mostly short gaps, sometimes long ones
	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 50) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_word(req_t w);
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		hit_q.push_back(box_hit(w));
		n_sent++;
	endtask

	// result side: random stalls, checking on accept
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			g = gap_len();
			rsp_stall <= (g > 0);
			repeat (g > 0 ? g : 1) begin
				@(posedge clk);
				if (rsp_valid && !rsp_stall) check_word();
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			if (rsp_valid && !rsp_stall) check_word();
		end
	end

	task automatic check_word();
		rsp_t e;
		if (hit_q.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
			return;
		end
		e = hit_q.pop_front();
		n_recv++;
		if (rsp.hit) n_hits++;
		if (rsp.hit !== e.hit) begin
			$error("hit exp %0d got %0d", e.hit, rsp.hit); errors++; end
		if (rsp.distance !== e.distance) begin
			$error("distance exp %0d got %0d", e.distance, rsp.distance); errors++; end
		if (rsp.point_x !== e.point_x) begin
			$error("point_x exp %0d got %0d", e.point_x, rsp.point_x); errors++; end
		if (rsp.point_y !== e.point_y) begin
			$error("point_y exp %0d got %0d", e.point_y, rsp.point_y); errors++; end
		if (rsp.point_z !== e.point_z) begin
			$error("point_z exp %0d got %0d", e.point_z, rsp.point_z); errors++; end
		if (rsp.face !== e.face) begin
			$error("face exp %0d got %0d", e.face, rsp.face); errors++; end
	endtask

	// watchdog on cycles with no accept on either channel
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WDOG_MAX) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		rsp_t miss;
		rsp_t e;
		miss = '0;
		// unit box at the origin, ray along +x from -5: hits face -x at 4
		e = '0; e.hit = 1; e.distance = q(4); e.point_x = q(-1); e.face = 0;
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), q(-5), 0, 0, q(1), 0, 0), 1, e});
		// same ray pointing away: miss
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), q(-5), 0, 0, q(-1), 0, 0), 1, miss});
		// origin inside, ray along +y: exits at +y face, distance 1
		e = '0; e.hit = 1; e.distance = q(1); e.point_y = q(1); e.face = 3;
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), 0, 0, 0, 0, q(1), 0), 1, e});
		// ray along -z from +5 hits +z face
		e = '0; e.hit = 1; e.distance = q(4); e.point_z = q(1); e.face = 5;
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), 0, 0, q(5), 0, 0, q(-1)), 1, e});
		// zero direction, origin outside slab: miss
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), q(3), 0, 0, 0, 0, 0), 1, miss});
		// all zero word
		rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, miss});
		// extremes
		rows.push_back('{mk(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
			0, 0, 0, 1, 1, 1), 0, miss});
		rows.push_back('{mk(S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX,
			S32_MAX, S32_MIN, S32_MAX, S32_MIN, S32_MAX, -1), 0, miss});
		rows.push_back('{mk(S32_MAX, S32_MAX, S32_MAX, S32_MIN, S32_MIN, S32_MIN,
			S32_MIN, S32_MIN, S32_MIN, S32_MAX, S32_MAX, S32_MAX), 0, miss});
		rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 0, miss});
		// inverted box
		rows.push_back('{mk(q(2), q(2), q(2), q(-2), q(-2), q(-2), q(-6), q(-6), q(-6),
			q(1), q(1), q(1)), 0, miss});
		// diagonal ray, tie among faces
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), q(-3), q(-3), q(-3),
			q(1), q(1), q(1)), 0, miss});
		// tiny direction saturates quotients
		rows.push_back('{mk(q(-1), q(-1), q(-1), q(1), q(1), q(1), q(-9), 0, 0,
			1, 0, 0), 0, miss});
		// large direction, extreme origin
		rows.push_back('{mk(q(100), q(-1), q(-1), q(200), q(1), q(1), 0, 0, 0,
			S32_MAX, 0, 0), 0, miss});
		rows.push_back('{mk(q(-30000), q(-30000), q(-30000), q(30000), q(30000), q(30000),
			S32_MIN, 0, 0, S32_MAX, -1, 1), 0, miss});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed && box_hit(rows[i].w) !== rows[i].exp) begin
				$error("directed row %0d: local model disagrees with typed result", i);
				errors++;
			end
			send_word(rows[i].w);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			// drain the pipe once midway
			if (i == N_RANDOM / 2) begin
				req_valid <= 1'b0;
				while (hit_q.size() != 0) @(posedge clk);
			end
			send_word(rnd_word());
		end
		req_valid <= 1'b0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d ray/box words, checked %0d results, %0d of them hits.",
			n_sent, n_recv, n_hits);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

FILE: sim.f
src/rbsi_pkg.sv
src/rbsi_slab_div.sv
src/rbsi_select.sv
src/rbsi_point.sv
src/ray_box_slab_intersect_top.sv
verif/tb_ray_box_slab_intersect_top.sv
